[rtl/wis_pkg.sv]
// wis_pkg: shared constants, word types and codes of the weighted index sampler
`timescale 1ns / 1ps

package wis_pkg;

  // table size and weight width
  localparam int DEPTH       = 256;
  localparam int WEIGHT_BITS = 16;

  // field widths of the words
  localparam int OP_W     = 2;
  localparam int WEIGHT_W = 16;
  localparam int DRAW_W   = 16;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 8;
  localparam int TOTAL_W  = 24;
  localparam int COUNT_W  = 9;

  // derived internal widths
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int PROD_W = DRAW_W + TOTAL_W;

  // low weight bits that take part in an append
  localparam logic [WEIGHT_W-1:0] WEIGHT_MASK = (WEIGHT_BITS >= WEIGHT_W) ?
      {WEIGHT_W{1'b1}} : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FIN
  } state_t;

  // input word
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [WEIGHT_W-1:0] weight;
    logic [DRAW_W-1:0]   draw;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  index;
    logic [TOTAL_W-1:0]  total;
    logic [COUNT_W-1:0]  count;
  } out_word_t;

endpackage

[rtl/wis_ram.sv]
// wis_ram: generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module wis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/weighted_index_sampler.sv]
// weighted_index_sampler: cumulative weight table with binary search sampling
// append, clear, unused op, sample of at most one entry or zero total: accept goes to ST_FIN
// other sample: ST_READ, then ST_CMP with one table read per search step, then ST_FIN
// one word at a time; ST_FIN loads the result word once the output register is free
// a new word is taken while the previous result word still waits in the output register
// reset: count and total clear at once; table contents stay undefined until appended
`timescale 1ns / 1ps

module weighted_index_sampler
  import wis_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    count;
  logic [TOTAL_W-1:0]  total;
  logic [TOTAL_W-1:0]  key;
  logic [ADDR_W-1:0]   lo;
  logic [ADDR_W-1:0]   hi;
  logic [ADDR_W-1:0]   mid;
  status_t             res_status;
  logic [ADDR_W-1:0]   res_index;

  logic                accept;
  logic                out_free;
  logic                full;
  logic [TOTAL_W:0]    sum;
  logic [TOTAL_W-1:0]  sum_sat;
  logic [PROD_W-1:0]   product;
  logic [ADDR_W-1:0]   lo_next;
  logic [ADDR_W-1:0]   hi_next;
  logic [ADDR_W-1:0]   mid_cur;
  logic [ADDR_W-1:0]   mid_next;
  logic [ADDR_W-1:0]   rd_addr;
  logic [TOTAL_W-1:0]  rd_data;
  logic                wr_en;

  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign full     = (count == CNT_W'(DEPTH));

  // saturating running sum for an append
  assign sum     = {1'b0, total} + (TOTAL_W + 1)'(in_data.weight & WEIGHT_MASK);
  assign sum_sat = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // search key scale: draw times total
  assign product = PROD_W'(in_data.draw) * PROD_W'(total);

  // one search step on the entry read back
  always_comb begin
    lo_next = lo;
    hi_next = hi;
    if (rd_data > key) begin
      hi_next = mid;
    end else begin
      lo_next = mid + ADDR_W'(1);
    end
  end

  assign mid_cur  = lo + ((hi - lo) >> 1);
  assign mid_next = lo_next + ((hi_next - lo_next) >> 1);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (op_t'(in_data.op) == OP_SAMPLE && count > CNT_W'(1) && total != '0) begin
            state_next = ST_READ;
          end else begin
            state_next = ST_FIN;
          end
        end
      end
      ST_READ: begin
        state_next = ST_CMP;
      end
      ST_CMP: begin
        if (lo_next >= hi_next) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    rd_addr  = mid_cur;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        wr_en    = in_valid && op_t'(in_data.op) == OP_APPEND && !full;
      end
      ST_READ: begin
        rd_addr = mid_cur;
      end
      ST_CMP: begin
        rd_addr = mid_next;
      end
      ST_FIN: begin
        in_ready = 1'b0;
      end
      default: in_ready = 1'b0;
    endcase
  end

  // table of cumulative ends
  wis_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (sum_sat),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (op_t'(in_data.op))
          OP_APPEND: begin
            if (!full) begin
              count <= count + CNT_W'(1);
              total <= sum_sat;
            end
          end
          OP_CLEAR: begin
            count <= '0;
            total <= '0;
          end
          default: begin
            count <= count;
          end
        endcase
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key        <= product[PROD_W-1:DRAW_W];
      lo         <= '0;
      hi         <= count[ADDR_W-1:0] - ADDR_W'(1);
      res_index  <= '0;
      case (op_t'(in_data.op))
        OP_APPEND: begin
          if (full) begin
            res_status <= STAT_FULL;
          end else begin
            res_status <= STAT_OK;
          end
        end
        OP_SAMPLE: begin
          if (count == '0 || total == '0) begin
            res_status <= STAT_EMPTY;
          end else begin
            res_status <= STAT_OK;
          end
        end
        default: begin
          res_status <= STAT_OK;
        end
      endcase
    end
    if (state == ST_READ) begin
      mid <= mid_cur;
    end
    if (state == ST_CMP) begin
      lo        <= lo_next;
      hi        <= hi_next;
      mid       <= mid_next;
      res_index <= lo_next;
    end
    if (state == ST_FIN && out_free) begin
      out_data.status <= res_status;
      out_data.index  <= INDEX_W'(res_index);
      out_data.total  <= total;
      out_data.count  <= COUNT_W'(count);
    end
  end

  // count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count above table size");

  // search window stays ordered
  a_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> (lo <= hi))
    else $error("search window inverted");

  // table writes only happen on an accepted append
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (accept && state == ST_IDLE))
    else $error("table write outside an accepted append");

  // a clear empties the table state
  a_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && op_t'(in_data.op) == OP_CLEAR) |=> (count == '0 && total == '0))
    else $error("clear left entries behind");

  // sampled index lies inside the held entries
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && res_status == STAT_OK && count != '0)
      |-> (CNT_W'(res_index) < count))
    else $error("sampled index beyond held entries");

endmodule
